// ----- rtl/weighted_time_slice_pool_selector_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the slice selector
// Shared assertion forms; the using scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_TIME_SLICE_POOL_SELECTOR_MACROS_SVH
`define WEIGHTED_TIME_SLICE_POOL_SELECTOR_MACROS_SVH

// same-cycle implication
`define WTSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wtss_pkg.sv -----
// ----------------------------------------------------------------------------
// wtss_pkg
// Widths, constants, register indexes and mod-100 helpers for the selector.
// ----------------------------------------------------------------------------
`default_nettype none

package wtss_pkg;

    localparam int TIME_W     = 63;
    localparam int RATIO_W    = 7;
    localparam int INTERVAL_W = 16;
    localparam int PERIOD_W   = 26;   // interval_ms * 1000 fits below 2**26
    localparam int ACC_W      = 7;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 6;

    localparam int ACC_MOD    = 100;
    localparam int US_PER_MS  = 1000;

    localparam logic [RATIO_W-1:0]    RATIO_RESET    = 7'd50;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

    // register index = paddr[2]
    localparam logic REG_RATIO    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // v < 300 -> v mod 100
    function automatic logic [ACC_W-1:0] mod_reduce(input logic [8:0] v);
        logic [8:0] t;
        t = v;
        if (t >= 9'(2 * ACC_MOD))
            t = t - 9'(2 * ACC_MOD);
        else if (t >= 9'(ACC_MOD))
            t = t - 9'(ACC_MOD);
        return t[ACC_W-1:0];
    endfunction

    // Horner step of (q * r) mod 100 for one quotient bit, y < 100, r <= 100
    function automatic logic [ACC_W-1:0] mod_step(input logic [ACC_W-1:0] y,
                                                  input logic b,
                                                  input logic [RATIO_W-1:0] r);
        logic [8:0] v;
        v = {1'b0, y, 1'b0} + (b ? {2'b00, r} : 9'd0);
        return mod_reduce(v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wtss_if.sv -----
// ----------------------------------------------------------------------------
// wtss_req_if / wtss_res_if
// Valid/ready channels for timestamp requests and target answers.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtss_req_if;
    import wtss_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_us;
    modport source (output valid, output time_us, input ready);
    modport sink   (input valid, input time_us, output ready);
endinterface

interface wtss_res_if;
    logic valid;
    logic ready;
    logic selected_target;
    modport source (output valid, output selected_target, input ready);
    modport sink   (input valid, input selected_target, output ready);
endinterface

`default_nettype wire

// ----- rtl/wtss_cfg.sv -----
// ----------------------------------------------------------------------------
// wtss_cfg
// APB register file: slice ratio and slice interval.
// ----------------------------------------------------------------------------
`default_nettype none

module wtss_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wtss_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [wtss_pkg::DATA_W-1:0]     pwdata,
    output logic      [wtss_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    output logic      [wtss_pkg::RATIO_W-1:0]    ratio,
    output logic      [wtss_pkg::INTERVAL_W-1:0] interval
);
    import wtss_pkg::*;

    logic [RATIO_W-1:0]    ratio_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= RATIO_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_RATIO:    ratio_reg    <= pwdata[RATIO_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[INTERVAL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RATIO:    prdata = DATA_W'(ratio_reg);
            REG_INTERVAL: prdata = DATA_W'(interval_reg);
            default:      prdata = '0;
        endcase
    end

    assign ratio    = ratio_reg;
    assign interval = interval_reg;

endmodule

`default_nettype wire

// ----- rtl/wtss_div.sv -----
// ----------------------------------------------------------------------------
// wtss_div
// Bit-serial restoring divider: elapsed us / slice period. One compare and
// subtract per cycle; tracks quotient*ratio mod 100 as quotient bits appear.
// ----------------------------------------------------------------------------
`default_nettype none

module wtss_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wtss_pkg::TIME_W-1:0]   dividend,
    input  wire logic [wtss_pkg::PERIOD_W-1:0] divisor,
    input  wire logic [wtss_pkg::RATIO_W-1:0]  ratio,
    output wtss_pkg::div_stat_t                stat,
    output logic                               quot_nz,
    output logic      [wtss_pkg::PERIOD_W-1:0] rem,
    output logic      [wtss_pkg::ACC_W-1:0]    qr_mod
);
    import wtss_pkg::*;

    logic [TIME_W-1:0]   dvd_reg, dvd_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0]    y_reg, y_next;
    logic                nz_reg, nz_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [PERIOD_W:0]   trial;
    logic                ge;

    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        y_next    = y_reg;
        nz_next   = nz_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            y_next    = '0;
            nz_next   = 1'b0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
            rem_next = ge ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
            y_next   = mod_step(y_reg, ge, ratio);
            nz_next  = nz_reg | ge;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        y_reg   <= y_next;
        nz_reg  <= nz_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot_nz   = nz_reg;
    assign rem       = rem_reg;
    assign qr_mod    = y_reg;

endmodule

`default_nettype wire

// ----- rtl/weighted_time_slice_pool_selector.sv -----
// ----------------------------------------------------------------------------
// Answer path from the request beat: set in PREP when interval is zero or time
// is behind the slice start, via FIN on the first request, via LAUNCH and DIV
// (63-step serial divider) when no whole slice has passed, via LAUNCH, DIV, FIN
// when slices advance. One request in flight; ready rises after the answer beat.
// Reset (async, active low) clears owner, accumulator, started flag, slice start
// and registers (ratio 50, interval 1000 ms).
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_time_slice_pool_selector_macros.svh"

module weighted_time_slice_pool_selector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    wtss_req_if.sink                             req,
    wtss_res_if.source                           res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wtss_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [wtss_pkg::DATA_W-1:0]     pwdata,
    output logic      [wtss_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import wtss_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_LAUNCH = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [RATIO_W-1:0]    ratio;
    logic [INTERVAL_W-1:0] interval;
    logic [RATIO_W-1:0]    r_eff;

    logic [2:0]          state_reg, state_next;
    logic                started_reg, started_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                target_reg, target_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_sel_reg, out_sel_next;

    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [ACC_W-1:0]    bl_reg, bl_next;

    logic [TIME_W:0]     diff;
    logic [7:0]          sum;
    logic                accept;

    div_stat_t           div_stat;
    logic                quot_nz;
    logic [PERIOD_W-1:0] rem;
    logic [ACC_W-1:0]    qr_mod;

    wtss_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ratio    (ratio),
        .interval (interval)
    );

    wtss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_LAUNCH),
        .dividend (elapsed_reg),
        .divisor  (period_reg),
        .ratio    (r_eff),
        .stat     (div_stat),
        .quot_nz  (quot_nz),
        .rem      (rem),
        .qr_mod   (qr_mod)
    );

    assign r_eff     = (ratio > RATIO_W'(ACC_MOD)) ? RATIO_W'(ACC_MOD) : ratio;
    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = req.valid && req.ready;
    assign res.valid = out_valid_reg;
    assign res.selected_target = out_sel_reg;

    // borrow bit set when now is behind the slice start
    assign diff = {1'b0, now_reg} - {1'b0, start_reg};
    assign sum  = {1'b0, bl_reg} + {1'b0, r_eff};

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg;
        out_sel_next   = out_sel_reg;
        now_next       = now_reg;
        elapsed_next   = elapsed_reg;
        period_next    = period_reg;
        bl_next        = bl_reg;

        if (res.valid && res.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next   = req.time_us;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    start_next   = now_reg;
                    bl_next      = acc_reg;
                    state_next   = S_FIN;
                end
                else if (interval == '0 || diff[TIME_W])
                begin
                    out_valid_next = 1'b1;
                    out_sel_next   = target_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    elapsed_next = diff[TIME_W-1:0];
                    period_next  = PERIOD_W'(interval) * PERIOD_W'(US_PER_MS);
                    state_next   = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (quot_nz)
                    begin
                        start_next = now_reg - TIME_W'(rem);
                        // accumulator before the last advance: acc + (n-1)*r mod 100
                        bl_next    = mod_reduce(9'(acc_reg) + 9'(qr_mod)
                                                + (9'(ACC_MOD) - 9'(r_eff)));
                        state_next = S_FIN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_sel_next   = target_reg;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (sum >= 8'(ACC_MOD))
                begin
                    acc_next    = ACC_W'(sum - 8'(ACC_MOD));
                    target_next = 1'b0;
                end
                else
                begin
                    acc_next    = sum[ACC_W-1:0];
                    target_next = 1'b1;
                end
                out_valid_next = 1'b1;
                out_sel_next   = target_next;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            acc_reg       <= '0;
            target_reg    <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            acc_reg       <= acc_next;
            target_reg    <= target_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            out_sel_reg   <= out_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        period_reg  <= period_next;
        bl_reg      <= bl_next;
    end

    `WTSS_ASSERT_IMP(a_div_state, div_stat.busy || div_stat.done, state_reg == S_DIV, "div busy")
    `WTSS_ASSERT_IMP(a_acc_range, 1'b1, acc_reg < ACC_W'(ACC_MOD), "accumulator out of range")
    `WTSS_ASSERT_IMP(a_unstarted, !started_reg, acc_reg == '0 && !target_reg, "early move")
    `WTSS_ASSERT_NXT(a_launch_busy, state_reg == S_LAUNCH, div_stat.busy, "no div start")

endmodule

`default_nettype wire
